### rtl/pstbl_pkg.sv
package pstbl_pkg;

    // Result codes
    localparam logic [1:0] VERDICT_DROP     = 2'd0;
    localparam logic [1:0] VERDICT_ALLOW    = 2'd1;
    localparam logic [1:0] VERDICT_CONFLICT = 2'd2;

    // Beat widths
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 32;
    localparam int ADDR_BITS  = 32;
    localparam int TIME_BITS  = 32;
    localparam int FIELD_BITS = 24;

    // Refill arithmetic: elapsed (32) * rate (24) gives a 56-bit product.
    // A product at or above 1000 * 2^24 adds at least 2^24 tokens, which
    // always saturates the bucket, so only smaller products are divided.
    localparam int          PROD_W        = TIME_BITS + FIELD_BITS;
    localparam logic [PROD_W-1:0] SAT_PRODUCT = PROD_W'(64'd16777216000);
    // Divide by 1000 as (p >> 3) / 125, the latter by reciprocal multiply;
    // exact for any dividend below 2^31.
    localparam int          DIV_IN_W      = 31;
    localparam int          RECIP_W       = 32;
    localparam logic [RECIP_W-1:0] RECIP_125 = 32'd2199023256;
    localparam int          RECIP_SHIFT   = 38;
    localparam int          RECIP_PROD_W  = DIV_IN_W + RECIP_W;
    localparam int          ADDED_W       = FIELD_BITS + 1;
    localparam logic [ADDED_W-1:0] ADDED_SAT = ADDED_W'(1) << FIELD_BITS;

    // Width of the token sum before saturation
    localparam int SUM_W = 33;

    // Control sequencer
    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_LOOKUP = 5'b00100,
        ST_DIVIDE = 5'b01000,
        ST_APPLY  = 5'b10000
    } state_t;

endpackage

### rtl/per_source_token_bucket_limiter.sv
// Per-source token bucket limiter over a direct-mapped table in one RAM.
// Flow: accept, table read, two multiplier stages of the refill divide-by-1000,
// then write-back and the registered result beat; write-back waits for a free
// result register, and no new packet is accepted until the last is written back.
// Reset: asynchronous, active low; afterwards a clearing pass writes every
// entry, during which s_axis_tready stays low.
module per_source_token_bucket_limiter
    import pstbl_pkg::*;
#(
    parameter int TABLE_ENTRIES = 1024,
    parameter int TOKEN_BITS    = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // source_address[31:0], now_ms[63:32], refill_rate[87:64], burst_cap[111:88]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // verdict[1:0], tokens_left[25:2], zero fill[31:26]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int ENTRY_W = 1 + ADDR_BITS + TIME_BITS + TOKEN_BITS;
    localparam logic [SUM_W-1:0] TOKEN_MAX = (SUM_W'(1) << TOKEN_BITS) - SUM_W'(1);

    state_t state_reg, state_next;

    logic [IDX_W-1:0]      clr_idx_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [ADDR_BITS-1:0]  src_reg;
    logic [TIME_BITS-1:0]  now_reg;
    logic [FIELD_BITS-1:0] rate_reg;
    logic [FIELD_BITS-1:0] burst_reg;

    logic                  out_valid_reg;
    logic [1:0]            out_verdict_reg;
    logic [FIELD_BITS-1:0] out_tokens_reg;

    logic                  in_fire;
    logic                  out_free;
    logic                  apply_fire;
    logic [ADDR_BITS-1:0]  in_src;
    logic [ADDR_BITS-1:0]  in_mixed;
    logic [IDX_W-1:0]      in_idx;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [ENTRY_W-1:0]    mem_wdata;
    logic [ENTRY_W-1:0]    rd_entry;

    logic                  rd_valid;
    logic [ADDR_BITS-1:0]  rd_src;
    logic [TIME_BITS-1:0]  rd_time;
    logic [TOKEN_BITS-1:0] rd_tokens;

    logic [ADDED_W-1:0]    added;
    logic [SUM_W-1:0]      burst_eff;
    logic [SUM_W-1:0]      old_tokens;
    logic [SUM_W-1:0]      total;
    logic [SUM_W-1:0]      total_sat;
    logic [SUM_W-1:0]      stored;
    logic [1:0]            verdict;
    logic [SUM_W-1:0]      left;

    // Handshake
    assign in_fire    = s_axis_tvalid && s_axis_tready;
    assign out_free   = !out_valid_reg || m_axis_tready;
    assign apply_fire = (state_reg == ST_APPLY) && out_free;

    // Fold the address into the table index
    assign in_src   = s_axis_tdata[ADDR_BITS-1:0];
    assign in_mixed = in_src ^ {16'b0, in_src[31:16]};
    assign in_idx   = in_mixed[IDX_W-1:0];

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_idx_reg == {IDX_W{1'b1}}) state_next = ST_IDLE;
            ST_IDLE:   if (s_axis_tvalid) state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = ST_DIVIDE;
            ST_DIVIDE: state_next = ST_APPLY;
            ST_APPLY:  if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
            end
        end
    end

    // Hold the packet fields while it is worked on
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            idx_reg   <= in_idx;
            src_reg   <= in_src;
            now_reg   <= s_axis_tdata[63:32];
            rate_reg  <= s_axis_tdata[87:64];
            burst_reg <= s_axis_tdata[111:88];
        end
    end

    // Table
    pstbl_table_ram #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (ENTRY_W)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (in_fire),
        .raddr (in_idx),
        .rdata (rd_entry)
    );

    assign rd_valid  = rd_entry[ENTRY_W-1];
    assign rd_src    = rd_entry[TOKEN_BITS+TIME_BITS +: ADDR_BITS];
    assign rd_time   = rd_entry[TOKEN_BITS +: TIME_BITS];
    assign rd_tokens = rd_entry[TOKEN_BITS-1:0];

    // Refill amount, ready in ST_APPLY
    pstbl_refill u_refill (
        .clk     (clk),
        .elapsed (now_reg - rd_time),
        .rate    (rate_reg),
        .added   (added)
    );

    // Bucket update
    always_comb
    begin
        burst_eff  = (SUM_W'(burst_reg) > TOKEN_MAX) ? TOKEN_MAX : SUM_W'(burst_reg);
        old_tokens = SUM_W'(rd_tokens);
        total      = old_tokens + SUM_W'(added);
        total_sat  = (total > burst_eff) ? burst_eff : total;
        if (!rd_valid)
        begin
            verdict = VERDICT_ALLOW;
            stored  = burst_eff;
            left    = burst_eff;
        end
        else if (rd_src != src_reg)
        begin
            verdict = VERDICT_CONFLICT;
            stored  = old_tokens;
            left    = '0;
        end
        else if (total_sat == '0)
        begin
            verdict = VERDICT_DROP;
            stored  = old_tokens;
            left    = old_tokens;
        end
        else
        begin
            verdict = VERDICT_ALLOW;
            stored  = total_sat - SUM_W'(1);
            left    = total_sat - SUM_W'(1);
        end
    end

    // Write back: clearing pass, or the updated entry
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = apply_fire && (verdict != VERDICT_CONFLICT);
            mem_waddr = idx_reg;
            mem_wdata = {1'b1, src_reg, now_reg, stored[TOKEN_BITS-1:0]};
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (apply_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (apply_fire)
        begin
            out_verdict_reg <= verdict;
            out_tokens_reg  <= left[FIELD_BITS-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_tokens_reg, out_verdict_reg};

    // Checks
    a_accept_starts_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_LOOKUP))
        else $error("accepted beat did not start a table lookup");

    a_write_only_clear_or_apply: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_APPLY))
        else $error("table written outside clear or write-back");

    a_conflict_reports_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_verdict_reg == VERDICT_CONFLICT) |-> (out_tokens_reg == '0))
        else $error("conflict verdict with nonzero token count");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_verdict_reg == VERDICT_DROP ||
                           out_verdict_reg == VERDICT_ALLOW ||
                           out_verdict_reg == VERDICT_CONFLICT))
        else $error("undefined verdict code");

    a_no_result_without_packet: assert property (@(posedge clk) disable iff (!rst_n)
        apply_fire |-> $past(state_reg == ST_DIVIDE || state_reg == ST_APPLY))
        else $error("write-back without a preceding refill computation");

endmodule

### rtl/pstbl_table_ram.sv
module pstbl_table_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 89,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/pstbl_refill.sv
module pstbl_refill
    import pstbl_pkg::*;
(
    input  logic                  clk,
    input  logic [TIME_BITS-1:0]  elapsed,
    input  logic [FIELD_BITS-1:0] rate,
    output logic [ADDED_W-1:0]    added
);

    logic [PROD_W-1:0]       prod_reg;
    logic                    big_reg;
    logic [RECIP_PROD_W-1:0] recip_reg;
    logic [DIV_IN_W-1:0]     div_in;

    // Stage 1: elapsed milliseconds times tokens per second
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(elapsed) * PROD_W'(rate);
    end

    // Stage 2: flag saturation, scale by the reciprocal of 125
    assign div_in = prod_reg[DIV_IN_W+2:3];

    always_ff @(posedge clk)
    begin
        big_reg   <= (prod_reg >= SAT_PRODUCT);
        recip_reg <= RECIP_PROD_W'(div_in) * RECIP_PROD_W'(RECIP_125);
    end

    // Quotient below 2^24 unless the product was large
    assign added = big_reg ? ADDED_SAT
                           : recip_reg[RECIP_SHIFT+ADDED_W-1:RECIP_SHIFT];

endmodule

### dv/tb_per_source_token_bucket_limiter.sv
`timescale 1ns / 100ps

module tb_per_source_token_bucket_limiter;
    import pstbl_pkg::*;

    localparam int TABLE_ENTRIES = 1024;
    localparam int MS_PER_S      = 1000;
    localparam int POOL_SIZE     = 16;
    localparam int LONG_HOLD     = 400;
    localparam int DRAIN_CYCLES  = 20;

    // Packet beat, last field in the lowest bits
    typedef struct packed {
        logic [23:0] burst;
        logic [23:0] rate;
        logic [31:0] now_ms;
        logic [31:0] src;
    } packet_t;

    typedef struct {
        logic [1:0]  verdict;
        logic [23:0] tokens_left;
    } verdict_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // source_address[31:0], now_ms[63:32], refill_rate[87:64], burst_cap[111:88]
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // verdict[1:0], tokens_left[25:2], zero fill[31:26]
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // Shadow of the source table
    bit          bucket_valid  [TABLE_ENTRIES];
    logic [31:0] bucket_src    [TABLE_ENTRIES];
    logic [31:0] bucket_time   [TABLE_ENTRIES];
    logic [23:0] bucket_tokens [TABLE_ENTRIES];

    packet_t  packet_queue[$];
    verdict_t verdict_queue[$];
    packet_t  cur_pkt;
    verdict_t want;
    int       mismatch_count = 0;
    int       send_idle_pct = 10;
    int       recv_idle_pct = 73;
    int       stall_req = 0;
    int       stall_seen = 0;
    int       hold_cycles = 0;

    // Traffic pool for well-formed per-source sequences
    logic [31:0] pool_src   [POOL_SIZE];
    logic [23:0] pool_rate  [POOL_SIZE];
    logic [23:0] pool_burst [POOL_SIZE];
    logic [31:0] sim_ms;

    per_source_token_bucket_limiter #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .TOKEN_BITS   (24)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Police one packet against the shadow table and return its verdict
    function automatic verdict_t police_packet(input packet_t p);
        int          slot;
        logic [31:0] elapsed;
        logic [63:0] refill;
        logic [63:0] level;
        verdict_t    r;
        slot = (p.src ^ (p.src >> 16)) % TABLE_ENTRIES;
        if (!bucket_valid[slot])
        begin
            // Empty slot: create the entry with a full bucket
            bucket_valid[slot]  = 1'b1;
            bucket_src[slot]    = p.src;
            bucket_time[slot]   = p.now_ms;
            bucket_tokens[slot] = p.burst;
            r.verdict     = VERDICT_ALLOW;
            r.tokens_left = p.burst;
        end
        else if (bucket_src[slot] != p.src)
        begin
            r.verdict     = VERDICT_CONFLICT;
            r.tokens_left = '0;
        end
        else
        begin
            // Refill by modular elapsed time, saturate at the burst limit
            elapsed = p.now_ms - bucket_time[slot];
            refill  = (64'(elapsed) * 64'(p.rate)) / 64'(MS_PER_S);
            level   = 64'(bucket_tokens[slot]) + refill;
            if (level > 64'(p.burst))
                level = 64'(p.burst);
            bucket_time[slot] = p.now_ms;
            if (level == 0)
            begin
                r.verdict     = VERDICT_DROP;
                r.tokens_left = bucket_tokens[slot];
            end
            else
            begin
                bucket_tokens[slot] = 24'(level - 1);
                r.verdict     = VERDICT_ALLOW;
                r.tokens_left = 24'(level - 1);
            end
        end
        return r;
    endfunction

    task automatic push_pkt(input logic [31:0] src, input logic [31:0] now_ms,
                            input logic [23:0] rate, input logic [23:0] burst);
        packet_t p;
        p.src    = src;
        p.now_ms = now_ms;
        p.rate   = rate;
        p.burst  = burst;
        packet_queue.push_back(p);
    endtask

    // Mostly pool traffic with a running clock; the rest conflicts, noise and clock jumps
    task automatic queue_random_traffic(input int count);
        int      pick;
        int      k;
        packet_t p;
        repeat (count)
        begin
            pick   = $urandom_range(99);
            k      = $urandom_range(POOL_SIZE - 1);
            sim_ms = sim_ms + $urandom_range(15);
            if (pick < 5)
            begin
                pool_rate[k]  = 24'($urandom_range(3000));
                pool_burst[k] = 24'($urandom_range(1, 12));
            end
            p.src    = pool_src[k];
            p.now_ms = sim_ms;
            p.rate   = pool_rate[k];
            p.burst  = pool_burst[k];
            if (pick >= 70 && pick < 80)
            begin
                // Same slot, other source
                p.src = pool_src[k] ^ (32'($urandom_range(1, 63)) << 26);
            end
            else if (pick >= 80 && pick < 90)
            begin
                p.src    = $urandom;
                p.now_ms = $urandom;
                p.rate   = 24'($urandom);
                p.burst  = 24'($urandom);
            end
            else if (pick >= 90)
            begin
                // Jump the clock anywhere, full-range rate, full-range or small limit
                p.now_ms = $urandom;
                p.rate   = 24'($urandom);
                p.burst  = pick[0] ? 24'($urandom) : 24'($urandom_range(40));
            end
            packet_queue.push_back(p);
        end
    endtask

    task automatic wait_drained;
        while (packet_queue.size() != 0 || s_axis_tvalid || verdict_queue.size() != 0)
            @(negedge clk);
    endtask

    // Stimulus and run control
    initial
    begin
        // Drain a bucket, then refill it by one token
        push_pkt(32'h0000_0001, 32'd100, 24'd1000, 24'd3);
        repeat (4) push_pkt(32'h0000_0001, 32'd100, 24'd1000, 24'd3);
        push_pkt(32'h0000_0001, 32'd101, 24'd1000, 24'd3);
        // Other sources landing on a taken slot
        push_pkt(32'h0001_0000, 32'd102, 24'd5, 24'd5);
        push_pkt(32'hFFFF_FFFE, 32'hFFFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
        // Extremes: full limit, wrap of the clock, clock going backwards
        push_pkt(32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
        push_pkt(32'hFFFF_FFFF, 32'h0000_0000, 24'hFF_FFFF, 24'hFF_FFFF);
        push_pkt(32'hFFFF_FFFF, 32'hFFFF_FFF0, 24'hFF_FFFF, 24'hFF_FFFF);
        push_pkt(32'h0000_0000, 32'h0000_0000, 24'd0, 24'd0);
        // Limit falls to zero with tokens still stored
        push_pkt(32'h0000_0002, 32'd0, 24'd0, 24'd5);
        push_pkt(32'h0000_0002, 32'd0, 24'd0, 24'd0);
        push_pkt(32'h0000_0002, 32'd7, 24'd0, 24'd10);
        push_pkt(32'h0000_0002, 32'hFFFF_FFFF, 24'd0, 24'd10);
        // Zero-limit source: created empty, then rate limited
        push_pkt(32'h0000_0003, 32'd50, 24'd0, 24'd0);
        push_pkt(32'h0000_0003, 32'd90, 24'd0, 24'd0);
        // Refill below one token truncates to nothing
        push_pkt(32'h0000_0004, 32'd0, 24'd999, 24'd1000);
        push_pkt(32'h0000_0004, 32'd1, 24'd999, 24'd1000);
        push_pkt(32'h0000_0004, 32'd1001, 24'd999, 24'd1000);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        wait_drained();

        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_src[i]   = $urandom;
            pool_rate[i]  = 24'($urandom_range(3000));
            pool_burst[i] = 24'($urandom_range(1, 12));
        end
        sim_ms = 32'hFFFF_FC00;

        // Sender rarely idles, receiver mostly stalls
        queue_random_traffic(380);
        wait_drained();

        // Other way round
        send_idle_pct = 73;
        recv_idle_pct = 10;
        queue_random_traffic(380);
        wait_drained();

        // Full rate, opened by a long receiver hold-off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_req     = stall_req + 1;
        queue_random_traffic(380);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Drive packet beats and predict each one as it is accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                verdict_queue.push_back(police_packet(cur_pkt));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (packet_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_pkt = packet_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= cur_pkt;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Check verdict beats and pace the receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (verdict_queue.size() == 0)
                begin
                    $display("%0t: unexpected verdict beat, expected none, actual %h",
                             $time, m_axis_tdata);
                    mismatch_count = mismatch_count + 1;
                end
                else
                begin
                    want = verdict_queue.pop_front();
                    if (m_axis_tdata[1:0] !== want.verdict)
                    begin
                        $display("%0t: verdict expected %0d actual %0d",
                                 $time, want.verdict, m_axis_tdata[1:0]);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (m_axis_tdata[25:2] !== want.tokens_left)
                    begin
                        $display("%0t: tokens_left expected %0d actual %0d",
                                 $time, want.tokens_left, m_axis_tdata[25:2]);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (m_axis_tdata[31:26] !== 6'd0)
                    begin
                        $display("%0t: fill bits expected 0 actual %h",
                                 $time, m_axis_tdata[31:26]);
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
            if (stall_seen != stall_req)
            begin
                stall_seen    <= stall_req;
                hold_cycles   <= LONG_HOLD;
                m_axis_tready <= 1'b0;
            end
            else if (hold_cycles > 0)
            begin
                hold_cycles   <= hold_cycles - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

endmodule
